[rtl/frame_time_histogram_top_k_assert.svh]
// assertion macros for the frame time histogram block
// expects signals named clk and rst_n in the scope of use
`ifndef FRAME_TIME_HISTOGRAM_TOP_K_ASSERT_SVH
`define FRAME_TIME_HISTOGRAM_TOP_K_ASSERT_SVH

// same-cycle implication, off while in reset
`define FTH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fth assertion failed");

// next-cycle implication, off while in reset
`define FTH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fth assertion failed");

`endif

[rtl/fth_pkg.sv]
// shared constants, types and helpers of the frame time histogram block
// no dependencies
`timescale 1ns / 1ps

package fth_pkg;

  localparam int KEEP_DEPTH    = 16;
  localparam int DURATION_BITS = 32;

  localparam int DUR_FIELD_W = 32;
  localparam int DUR_W       = (DURATION_BITS < DUR_FIELD_W) ? DURATION_BITS : DUR_FIELD_W;
  localparam int FILL_W      = $clog2(KEEP_DEPTH + 1);
  localparam int IDX_W       = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
  localparam int NUM_BINS    = 5;
  localparam int NUM_LIMITS  = 4;
  localparam int CNT_W       = $clog2(KEEP_DEPTH + NUM_BINS + 1);
  localparam int KIND_W      = 2;
  localparam int BIN_W       = 3;
  localparam int RANK_W      = 4;
  localparam int FNUM_W      = 32;
  localparam int TALLY_W     = 32;
  localparam int TSUM_W      = 48;
  localparam int KEEP_W      = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 5;
  localparam int REG_IDX_W   = 3;

  // operations
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BIN    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TOTALS = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEEP    = 3'd4;

  // reset values: 120/60/30/15 fps frame bounds in microseconds
  localparam logic [CFG_DATA_W-1:0] LIMIT_0_RST = 32'd8333;
  localparam logic [CFG_DATA_W-1:0] LIMIT_1_RST = 32'd16667;
  localparam logic [CFG_DATA_W-1:0] LIMIT_2_RST = 32'd33333;
  localparam logic [CFG_DATA_W-1:0] LIMIT_3_RST = 32'd66667;
  localparam logic [KEEP_W-1:0]     KEEP_RST    = 5'd16;

  typedef logic [NUM_LIMITS-1:0][CFG_DATA_W-1:0] limits_t;
  typedef logic [NUM_BINS-1:0][TALLY_W-1:0]      bin_tally_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              ins;
    logic [DUR_W-1:0]  dur;
    logic [FNUM_W-1:0] fnum;
  } cell_ctl_t;

  // what a cell hands to its right-hand neighbor
  typedef struct packed {
    logic              ge;
    logic [DUR_W-1:0]  dur;
    logic [FNUM_W-1:0] fnum;
  } cell_link_t;

  // effective list length: 0 acts as 1, clipped at the chain depth
  function automatic logic [FILL_W-1:0] keep_limit(input logic [KEEP_W-1:0] kc);
    int k;
    k = int'(kc);
    if (k == 0) begin
      k = 1;
    end else if (k > KEEP_DEPTH) begin
      k = KEEP_DEPTH;
    end
    return FILL_W'(k);
  endfunction

endpackage

[rtl/fth_in_if.sv]
// input beat channel of the frame time histogram block
// depends on fth_pkg
`timescale 1ns / 1ps

interface fth_in_if;
  import fth_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [DUR_FIELD_W-1:0] frame_duration;

  modport source (output valid, output operation, output frame_duration, input ready);
  modport sink (input valid, input operation, input frame_duration, output ready);
endinterface

[rtl/fth_out_if.sv]
// result beat channel of the frame time histogram block
// depends on fth_pkg
`timescale 1ns / 1ps

interface fth_out_if;
  import fth_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      result_kind;
  logic [BIN_W-1:0]       bin;
  logic [RANK_W-1:0]      rank;
  logic                   recorded;
  logic [DUR_FIELD_W-1:0] entry_duration;
  logic [FNUM_W-1:0]      frame_number;
  logic [TALLY_W-1:0]     tally;
  logic [TSUM_W-1:0]      time_sum;
  logic                   last;

  modport source (output valid, output result_kind, output bin, output rank,
                  output recorded, output entry_duration, output frame_number,
                  output tally, output time_sum, output last, input ready);
  modport sink (input valid, input result_kind, input bin, input rank,
                input recorded, input entry_duration, input frame_number,
                input tally, input time_sum, input last, output ready);
endinterface

[rtl/frame_time_histogram_top_k.sv]
// frame time histogram with a ranked chain of the longest frames
// top level; depends on fth_pkg, fth_in_if, fth_out_if, fth_cell, fth_stats
//
// usage
//   in_bus carries one beat per command: operation 0 records frame_duration,
//   operation 1 asks for a report. out_bus returns result beats, each with
//   last set on the final beat of its command.
//   a record gives one verdict beat (bin, insertion rank, recorded flag and
//   frame number) in the cycle after acceptance; records are taken every cycle
//   while out_bus drains, so the sustained rate is one frame per cycle. the
//   insertion chain compares all kept cells against the new duration in
//   parallel and shifts them as the record is accepted.
//   a report streams fill + 6 beats (kept entries longest first, five bins,
//   totals); the first passes the sequencer state and the output register, then
//   one per cycle while taken; in_bus is held off until the totals beat is loaded.
//   a stalled receiver holds the output register; a new beat is taken only
//   when that register is empty or being emptied in the same cycle.
//   reset (rst_n low, synchronous) empties the kept list, clears the counters
//   and restores the register defaults; no clearing pass is needed.
//   registers sit on an apb-style port at byte address 4*i: bin_limit_0..3,
//   keep_count. write them only while the block is idle.
`timescale 1ns / 1ps

`include "frame_time_histogram_top_k_assert.svh"

module frame_time_histogram_top_k (
  input  logic                           clk,
  input  logic                           rst_n,
  fth_in_if.sink                         in_bus,
  fth_out_if.source                      out_bus,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fth_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fth_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fth_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import fth_pkg::*;

  // controller states
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REPORT = 1'b1;

  // configuration registers
  limits_t                limit_r;
  logic [KEEP_W-1:0]      keep_r;
  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic [FILL_W-1:0]      lim;
  logic [FILL_W-1:0]      new_lim;

  // control state
  logic                   state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [FILL_W-1:0]      fill_r;

  // handshake
  logic                   in_acc;
  logic                   rec_acc;
  logic                   rpt_acc;
  logic                   out_free;

  // chain
  cell_ctl_t              cell_ctl;
  cell_link_t             link [KEEP_DEPTH+1];
  logic [KEEP_DEPTH-1:0]  occ;
  logic [KEEP_DEPTH-1:0]  take;
  logic [IDX_W-1:0]       pos;
  logic                   rec;
  logic [DUR_W-1:0]       dur_in;

  // statistics
  logic [BIN_W-1:0]       frame_bin;
  bin_tally_t             bin_count;
  logic [FNUM_W-1:0]      frame_total;
  logic [TSUM_W-1:0]      dur_total;

  // report beat
  logic [CNT_W-1:0]       fill_ext;
  logic [CNT_W-1:0]       cnt_end;
  logic [CNT_W-1:0]       bin_off;
  logic [FILL_W-1:0]      ent_sel;
  logic [KIND_W-1:0]      rpt_kind;
  logic [BIN_W-1:0]       rpt_bin;
  logic [RANK_W-1:0]      rpt_rank;
  logic [DUR_FIELD_W-1:0] rpt_dur;
  logic [FNUM_W-1:0]      rpt_fnum;
  logic [TALLY_W-1:0]     rpt_tally;
  logic [TSUM_W-1:0]      rpt_tsum;
  logic                   rpt_last;

  // output register
  logic                   out_valid_r;
  logic [KIND_W-1:0]      kind_r;
  logic [BIN_W-1:0]       bin_r;
  logic [RANK_W-1:0]      rank_r;
  logic                   recd_r;
  logic [DUR_FIELD_W-1:0] edur_r;
  logic [FNUM_W-1:0]      fnum_r;
  logic [TALLY_W-1:0]     tally_r;
  logic [TSUM_W-1:0]      tsum_r;
  logic                   last_r;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign lim     = keep_limit(keep_r);
  assign new_lim = keep_limit(pwdata[KEEP_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r[0] <= LIMIT_0_RST;
      limit_r[1] <= LIMIT_1_RST;
      limit_r[2] <= LIMIT_2_RST;
      limit_r[3] <= LIMIT_3_RST;
      keep_r     <= KEEP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LIMIT_0: limit_r[0] <= pwdata;
        REG_LIMIT_1: limit_r[1] <= pwdata;
        REG_LIMIT_2: limit_r[2] <= pwdata;
        REG_LIMIT_3: limit_r[3] <= pwdata;
        REG_KEEP:    keep_r     <= pwdata[KEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIMIT_0: prdata = limit_r[0];
      REG_LIMIT_1: prdata = limit_r[1];
      REG_LIMIT_2: prdata = limit_r[2];
      REG_LIMIT_3: prdata = limit_r[3];
      REG_KEEP:    prdata = CFG_DATA_W'(keep_r);
      default:     prdata = '0;
    endcase
  end

  // ---------------- input handshake ----------------
  // next beat only when the output register is empty or draining
  assign out_free     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (state_r == ST_IDLE) && out_free;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign rec_acc      = in_acc && (in_bus.operation == OP_RECORD);
  assign rpt_acc      = in_acc && (in_bus.operation == OP_REPORT);
  assign dur_in       = in_bus.frame_duration[DUR_W-1:0];

  // ---------------- insertion chain ----------------
  // cell i is occupied below the fill mark; the head link says "keep going"
  assign link[0] = '{ge: 1'b1, dur: '0, fnum: '0};

  assign cell_ctl.ins  = rec_acc && rec;
  assign cell_ctl.dur  = dur_in;
  assign cell_ctl.fnum = frame_total;

  for (genvar g = 0; g < KEEP_DEPTH; g++) begin : g_cell
    assign occ[g] = FILL_W'(g) < fill_r;
    fth_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl),
      .occ   (occ[g]),
      .left  (link[g]),
      .right (link[g+1]),
      .take  (take[g])
    );
  end

  // one-hot take flag gives the insertion position
  always_comb begin
    pos = '0;
    for (int i = 0; i < KEEP_DEPTH; i++) begin
      if (take[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  // enters when there is room, or when it beats an occupied cell
  assign rec = (fill_r < lim) || ((take & occ) != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cfg_wr && (reg_idx == REG_KEEP)) begin
      // shrinking the list drops the shortest entries
      if (fill_r > new_lim) begin
        fill_r <= new_lim;
      end
    end else if (rec_acc && (fill_r < lim)) begin
      fill_r <= fill_r + FILL_W'(1);
    end
  end

  // ---------------- statistics ----------------
  fth_stats u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec_en      (rec_acc),
    .dur         (dur_in),
    .limits      (limit_r),
    .bin         (frame_bin),
    .bin_count   (bin_count),
    .frame_total (frame_total),
    .dur_total   (dur_total)
  );

  // ---------------- report sequencer ----------------
  assign fill_ext = CNT_W'(fill_r);
  assign cnt_end  = fill_ext + CNT_W'(NUM_BINS);
  assign bin_off  = cnt_r - fill_ext;
  // cell k drives link k+1
  assign ent_sel  = FILL_W'(cnt_r) + FILL_W'(1);

  // beat order: kept entries, then bins, then totals
  always_comb begin
    rpt_kind  = KIND_TOTALS;
    rpt_bin   = '0;
    rpt_rank  = '0;
    rpt_dur   = '0;
    rpt_fnum  = '0;
    rpt_tally = frame_total;
    rpt_tsum  = dur_total;
    rpt_last  = 1'b1;
    priority if (cnt_r < fill_ext) begin
      rpt_kind  = KIND_ENTRY;
      rpt_rank  = RANK_W'(cnt_r);
      rpt_dur   = DUR_FIELD_W'(link[ent_sel].dur);
      rpt_fnum  = link[ent_sel].fnum;
      rpt_tally = '0;
      rpt_tsum  = '0;
      rpt_last  = 1'b0;
    end else if (cnt_r < cnt_end) begin
      rpt_kind  = KIND_BIN;
      rpt_bin   = bin_off[BIN_W-1:0];
      rpt_tally = bin_count[bin_off[BIN_W-1:0]];
      rpt_tsum  = '0;
      rpt_last  = 1'b0;
    end else begin
      rpt_kind  = KIND_TOTALS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (rpt_acc) begin
            state_r <= ST_REPORT;
            cnt_r   <= '0;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            if (cnt_r == cnt_end) begin
              state_r <= ST_IDLE;
            end else begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_acc || ((state_r == ST_REPORT) && out_free)) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_acc) begin
      kind_r  <= KIND_FRAME;
      bin_r   <= frame_bin;
      rank_r  <= rec ? RANK_W'(pos) : '0;
      recd_r  <= rec;
      edur_r  <= '0;
      fnum_r  <= frame_total;
      tally_r <= '0;
      tsum_r  <= '0;
      last_r  <= 1'b1;
    end else if ((state_r == ST_REPORT) && out_free) begin
      kind_r  <= rpt_kind;
      bin_r   <= rpt_bin;
      rank_r  <= rpt_rank;
      recd_r  <= 1'b0;
      edur_r  <= rpt_dur;
      fnum_r  <= rpt_fnum;
      tally_r <= rpt_tally;
      tsum_r  <= rpt_tsum;
      last_r  <= rpt_last;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.result_kind    = kind_r;
  assign out_bus.bin            = bin_r;
  assign out_bus.rank           = rank_r;
  assign out_bus.recorded       = recd_r;
  assign out_bus.entry_duration = edur_r;
  assign out_bus.frame_number   = fnum_r;
  assign out_bus.tally          = tally_r;
  assign out_bus.time_sum       = tsum_r;
  assign out_bus.last           = last_r;

  // ---------------- checks ----------------
  // list never holds more than the configured length
  `FTH_ASSERT_NOW(a_fill_in_limit, 1'b1, fill_r <= lim)
  // a report blocks new commands until its totals beat is loaded
  `FTH_ASSERT_NOW(a_report_blocks_input, state_r == ST_REPORT, !in_bus.ready)
  // only the totals beat closes a report, and it is loaded on the way out
  `FTH_ASSERT_NOW(a_report_not_last, (state_r == ST_REPORT) && out_valid_r, !last_r)
  // a recorded frame shows its verdict in the next cycle
  `FTH_ASSERT_NEXT(a_record_verdict, rec_acc, out_valid_r && (kind_r == KIND_FRAME))
  // sequencer never runs past the totals beat
  `FTH_ASSERT_NOW(a_cnt_bound, state_r == ST_REPORT, cnt_r <= cnt_end)
endmodule

[rtl/fth_cell.sv]
// one cell of the ranked insertion chain: holds one kept duration and frame number
// depends on fth_pkg
`timescale 1ns / 1ps

module fth_cell (
  input  logic                clk,
  input  fth_pkg::cell_ctl_t  ctl,
  input  logic                occ,
  input  fth_pkg::cell_link_t left,
  output fth_pkg::cell_link_t right,
  output logic                take
);
  import fth_pkg::*;

  logic [DUR_W-1:0]  dur_r;
  logic [FNUM_W-1:0] fnum_r;
  logic              my_ge;

  // stays put when holding a duration at least as long as the new one
  assign my_ge = occ && (dur_r >= ctl.dur);
  assign take  = !my_ge && left.ge;

  assign right.ge   = my_ge;
  assign right.dur  = dur_r;
  assign right.fnum = fnum_r;

  always_ff @(posedge clk) begin
    if (ctl.ins && !my_ge) begin
      if (left.ge) begin
        dur_r  <= ctl.dur;
        fnum_r <= ctl.fnum;
      end else begin
        dur_r  <= left.dur;
        fnum_r <= left.fnum;
      end
    end
  end
endmodule

[rtl/fth_stats.sv]
// histogram binning, frame count and duration sum, all saturating
// depends on fth_pkg
`timescale 1ns / 1ps

module fth_stats (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rec_en,
  input  logic [fth_pkg::DUR_W-1:0]  dur,
  input  fth_pkg::limits_t           limits,
  output logic [fth_pkg::BIN_W-1:0]  bin,
  output fth_pkg::bin_tally_t        bin_count,
  output logic [fth_pkg::FNUM_W-1:0] frame_total,
  output logic [fth_pkg::TSUM_W-1:0] dur_total
);
  import fth_pkg::*;

  logic [CFG_DATA_W-1:0] dur_ext;
  bin_tally_t            bin_count_r;
  logic [FNUM_W-1:0]     frame_total_r;
  logic [TSUM_W-1:0]     dur_total_r;
  logic [TSUM_W:0]       sum_wide;

  assign dur_ext = CFG_DATA_W'(dur);

  // first matching limit wins
  always_comb begin
    priority if (dur_ext <= limits[0]) begin
      bin = BIN_W'(0);
    end else if (dur_ext <= limits[1]) begin
      bin = BIN_W'(1);
    end else if (dur_ext <= limits[2]) begin
      bin = BIN_W'(2);
    end else if (dur_ext <= limits[3]) begin
      bin = BIN_W'(3);
    end else begin
      bin = BIN_W'(4);
    end
  end

  assign sum_wide = {1'b0, dur_total_r} + (TSUM_W + 1)'(dur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r   <= '0;
      frame_total_r <= '0;
      dur_total_r   <= '0;
    end else if (rec_en) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        if ((bin == BIN_W'(b)) && (bin_count_r[b] != '1)) begin
          bin_count_r[b] <= bin_count_r[b] + TALLY_W'(1);
        end
      end
      if (frame_total_r != '1) begin
        frame_total_r <= frame_total_r + FNUM_W'(1);
      end
      dur_total_r <= sum_wide[TSUM_W] ? '1 : sum_wide[TSUM_W-1:0];
    end
  end

  assign bin_count   = bin_count_r;
  assign frame_total = frame_total_r;
  assign dur_total   = dur_total_r;
endmodule
